### rtl/core/spd_pkg.sv
// spd_pkg: shared types and constants for the serial packet deframer.
// No dependencies; every other file in rtl/core imports it.
`timescale 1ns / 1ps

package spd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 9;

    // Header is type, arg1, arg2, arg3
    localparam logic [POS_W-1:0] HEADER_BYTES = 9'd4;
    // Byte positions inside the header
    localparam logic [POS_W-1:0] POS_TYPE = 9'd0;
    localparam logic [POS_W-1:0] POS_ARG1 = 9'd1;
    // Bit of the type byte that announces a payload (mask 0x80)
    localparam int unsigned PAYLOAD_FLAG_BIT = 7;

    // One tagged byte as it leaves the block
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [POS_W-1:0]  position;
        logic [BYTE_W-1:0] packet_type;
        logic              is_header;
        logic              has_payload;
        logic              last;
        logic              checksum_error;
    } spd_result_t;

endpackage

### rtl/core/spd_in_if.sv
// spd_in_if: valid/ready channel carrying one received byte per request.
// Depends on spd_pkg for the byte width.
`timescale 1ns / 1ps

interface spd_in_if
    import spd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

### rtl/core/spd_out_if.sv
// spd_out_if: valid/ready channel carrying one tagged byte per request.
// Depends on spd_pkg for the field widths.
`timescale 1ns / 1ps

interface spd_out_if
    import spd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] packet_type;
    logic              is_header;
    logic              has_payload;
    logic              last;
    logic              checksum_error;

    modport source (
        output valid, output out_byte, output position, output packet_type,
        output is_header, output has_payload, output last, output checksum_error,
        input  ready
    );
    modport sink (
        input  valid, input out_byte, input position, input packet_type,
        input  is_header, input has_payload, input last, input checksum_error,
        output ready
    );
endinterface

### rtl/core/serial_packet_deframer.sv
// Serial packet deframer: takes one received byte per request on byte_stream and
// returns it on tagged_stream with its position in the packet, the packet type,
// header/payload/last flags and a checksum error flag on the last byte of payload
// packets (header bytes type, arg1, arg2, arg3; arg1 payload bytes and a checksum
// byte follow when type bit 7 is set). One byte is accepted every cycle while the
// output keeps pace; each byte passes an input register and a result register,
// with combinational tagging logic (a position counter, a length compare and an
// 8-bit adder) in between.
// Depends on spd_pkg, spd_in_if, spd_out_if and the spd_* stage modules.
`timescale 1ns / 1ps

module serial_packet_deframer
    import spd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    spd_in_if.sink   byte_stream,
    spd_out_if.source tagged_stream
);

    logic              stage_valid;
    logic              advance;
    logic [BYTE_W-1:0] stage_data;
    spd_result_t       result;
    spd_result_t       out_result;

    spd_input_stage u_input_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (byte_stream.valid),
        .in_ready    (byte_stream.ready),
        .in_data     (byte_stream.in_byte),
        .stage_valid (stage_valid),
        .advance     (advance),
        .stage_data  (stage_data)
    );

    spd_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .stage_data (stage_data),
        .result     (result)
    );

    spd_output_stage u_output_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .advance     (advance),
        .result      (result),
        .out_valid   (tagged_stream.valid),
        .out_ready   (tagged_stream.ready),
        .out_result  (out_result)
    );

    // Unpack the result onto the channel fields
    assign tagged_stream.out_byte       = out_result.out_byte;
    assign tagged_stream.position       = out_result.position;
    assign tagged_stream.packet_type    = out_result.packet_type;
    assign tagged_stream.is_header      = out_result.is_header;
    assign tagged_stream.has_payload    = out_result.has_payload;
    assign tagged_stream.last           = out_result.last;
    assign tagged_stream.checksum_error = out_result.checksum_error;

endmodule

### rtl/core/spd_input_stage.sv
// spd_input_stage: input register for received bytes.
// Depends on spd_pkg; feeds spd_tracker.
`timescale 1ns / 1ps

module spd_input_stage
    import spd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_data,
    output logic              stage_valid,
    input  logic              advance,
    output logic [BYTE_W-1:0] stage_data
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              load;

    // Take a new byte whenever the stage is empty or drains this cycle
    assign in_ready   = !valid_reg || advance;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_data;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

endmodule

### rtl/core/spd_tracker.sv
// spd_tracker: packet position tracking, length capture and checksum.
// Depends on spd_pkg; sits between spd_input_stage and spd_output_stage.
`timescale 1ns / 1ps

module spd_tracker
    import spd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [BYTE_W-1:0] stage_data,
    output spd_result_t       result
);

    logic [POS_W-1:0]  byte_index_reg,   byte_index_next;
    logic [POS_W-1:0]  total_length_reg, total_length_next;
    logic [BYTE_W-1:0] running_sum_reg,  running_sum_next;
    logic [BYTE_W-1:0] current_type_reg, current_type_next;

    logic              first_byte;
    logic [BYTE_W-1:0] type_eff;
    logic              payload;
    logic [POS_W-1:0]  length_eff;
    logic [BYTE_W-1:0] sum_eff;
    logic [POS_W:0]    pos_plus_one;
    logic              is_last;

    // Tag the byte against the packet state, with header fields taken live
    always_comb
    begin
        first_byte = (byte_index_reg == POS_TYPE);
        type_eff   = first_byte ? stage_data : current_type_reg;
        payload    = type_eff[PAYLOAD_FLAG_BIT];

        // For payload types, length is header + arg1 + checksum byte once arg1 arrives
        length_eff = first_byte ? HEADER_BYTES : total_length_reg;
        if ((byte_index_reg == POS_ARG1) && payload)
        begin
            length_eff = HEADER_BYTES + {1'b0, stage_data} + 9'd1;
        end

        sum_eff      = (first_byte ? '0 : running_sum_reg) + stage_data;
        pos_plus_one = {1'b0, byte_index_reg} + 10'd1;
        is_last      = (pos_plus_one >= {1'b0, length_eff});

        result.out_byte       = stage_data;
        result.position       = byte_index_reg;
        result.packet_type    = type_eff;
        result.is_header      = (byte_index_reg < HEADER_BYTES);
        result.has_payload    = payload;
        result.last           = is_last;
        result.checksum_error = is_last && payload && (sum_eff != '0);
    end

    // State update; the last byte rearms for a new header
    always_comb
    begin
        byte_index_next   = byte_index_reg;
        total_length_next = total_length_reg;
        running_sum_next  = running_sum_reg;
        current_type_next = current_type_reg;
        if (advance)
        begin
            current_type_next = type_eff;
            if (is_last)
            begin
                byte_index_next   = '0;
                total_length_next = HEADER_BYTES;
                running_sum_next  = '0;
            end
            else
            begin
                byte_index_next   = pos_plus_one[POS_W-1:0];
                total_length_next = length_eff;
                running_sum_next  = sum_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            total_length_reg <= HEADER_BYTES;
            running_sum_reg  <= '0;
            current_type_reg <= '0;
        end
        else
        begin
            byte_index_reg   <= byte_index_next;
            total_length_reg <= total_length_next;
            running_sum_reg  <= running_sum_next;
            current_type_reg <= current_type_next;
        end
    end

endmodule

### rtl/core/spd_output_stage.sv
// spd_output_stage: result register that decouples the output handshake.
// Depends on spd_pkg for the result type.
`timescale 1ns / 1ps

module spd_output_stage
    import spd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        stage_valid,
    output logic        advance,
    input  spd_result_t result,
    output logic        out_valid,
    input  logic        out_ready,
    output spd_result_t out_result
);

    logic        valid_reg;
    logic        valid_next;
    spd_result_t result_reg;

    // Room when empty or when the held result leaves this cycle
    assign advance    = stage_valid && (!valid_reg || out_ready);
    assign valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

### dv/serial_packet_deframer_tb.sv
// serial_packet_deframer_tb: self-checking bench for the serial packet deframer.
// Depends on spd_pkg, spd_in_if, spd_out_if and the deframer RTL; a built-in tagger
// predicts every tagged byte and the monitor compares it with what the block returns.
`timescale 1ns / 1ps

module serial_packet_deframer_tb;
    import spd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_BYTES = 1300;
    localparam int unsigned CALM_TAIL    = 200;
    localparam int unsigned LONG_STALL   = 100;
    localparam int unsigned STALL_AT     = 400;

    // One byte waiting to be offered; hold_for_drain makes the sender wait until
    // every tagged byte already in flight has come back
    typedef struct {
        logic [BYTE_W-1:0] b;
        bit                hold_for_drain;
    } byte_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    spd_in_if  byte_if ();
    spd_out_if tag_if ();

    serial_packet_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_stream   (byte_if),
        .tagged_stream (tag_if)
    );

    byte_req_t   pending[$];
    spd_result_t tagged_due[$];
    bit          drain_next;
    int unsigned total_items;
    int unsigned accepted_cnt;
    int unsigned checked_cnt;
    int unsigned errors;
    int unsigned cycle_cnt;
    int unsigned idle_left;
    int unsigned stall_left;
    bit          long_stall_done;
    logic        calm;

    // Tagger state
    logic [POS_W-1:0]  byte_idx;
    logic [POS_W-1:0]  pkt_len;
    logic [BYTE_W-1:0] run_sum;
    logic [BYTE_W-1:0] cur_type;

    // No idling once the run is near its end
    assign calm = (accepted_cnt + CALM_TAIL >= total_items);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Tag one accepted byte and advance the packet state
    function automatic spd_result_t tag_byte(logic [BYTE_W-1:0] b);
        spd_result_t      r;
        logic [POS_W-1:0] pos;
        logic             payload;
        pos = byte_idx;
        if (pos == POS_TYPE)
        begin
            cur_type = b;
            pkt_len  = HEADER_BYTES;
            run_sum  = '0;
        end
        payload = cur_type[PAYLOAD_FLAG_BIT];
        // arg1 sets the length: header, payload and checksum byte
        if (pos == POS_ARG1 && payload)
            pkt_len = HEADER_BYTES + POS_W'(b) + POS_W'(1);
        run_sum = run_sum + b;
        r.out_byte       = b;
        r.position       = pos;
        r.packet_type    = cur_type;
        r.is_header      = (pos < HEADER_BYTES);
        r.has_payload    = payload;
        r.last           = (pos + 1 >= pkt_len);
        r.checksum_error = r.last && payload && (run_sum != '0);
        if (r.last)
        begin
            byte_idx = '0;
            pkt_len  = HEADER_BYTES;
            run_sum  = '0;
        end
        else
            byte_idx = pos + POS_W'(1);
        return r;
    endfunction

    task automatic push_byte(logic [BYTE_W-1:0] b);
        byte_req_t req;
        req.b = b;
        req.hold_for_drain = drain_next;
        drain_next = 1'b0;
        pending.push_back(req);
    endtask

    // Header, and for payload types arg1 random bytes plus a checksum byte
    task automatic queue_packet(logic [BYTE_W-1:0] ptype, logic [BYTE_W-1:0] arg1,
                                logic [BYTE_W-1:0] arg2, logic [BYTE_W-1:0] arg3,
                                bit good_sum);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] pb;
        sum = ptype + arg1 + arg2 + arg3;
        push_byte(ptype);
        push_byte(arg1);
        push_byte(arg2);
        push_byte(arg3);
        if (ptype[PAYLOAD_FLAG_BIT])
        begin
            for (int i = 0; i < arg1; i++)
            begin
                pb = BYTE_W'($urandom);
                sum = sum + pb;
                push_byte(pb);
            end
            if (good_sum)
                push_byte(-sum);
            else
                push_byte(-sum + BYTE_W'($urandom_range(1, 255)));
        end
    endtask

    task automatic compare_field(string fld, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, fld, want, got);
            errors++;
        end
    endtask

    // Byte sender: offers the head of the pending queue, tags every accepted byte
    always @(posedge clk or negedge rst_n)
    begin : byte_sender
        int unsigned acc_now;
        if (!rst_n)
        begin
            byte_if.valid   <= 1'b0;
            byte_if.in_byte <= '0;
            accepted_cnt    <= 0;
            idle_left       <= 0;
            byte_idx = '0;
            pkt_len  = HEADER_BYTES;
            run_sum  = '0;
            cur_type = '0;
        end
        else
        begin
            acc_now = accepted_cnt;
            if (byte_if.valid && byte_if.ready)
            begin
                tagged_due.push_back(tag_byte(byte_if.in_byte));
                acc_now = acc_now + 1;
            end
            accepted_cnt <= acc_now;
            // A request still waiting for ready stays as it is
            if (!byte_if.valid || byte_if.ready)
            begin
                if (idle_left != 0)
                begin
                    byte_if.valid <= 1'b0;
                    idle_left <= idle_left - 1;
                end
                else if (pending.size() == 0 ||
                         (pending[0].hold_for_drain && acc_now != checked_cnt))
                    byte_if.valid <= 1'b0;
                else if (!calm && $urandom_range(0, 11) == 0)
                begin
                    // random idle burst, this one included
                    byte_if.valid <= 1'b0;
                    idle_left <= $urandom_range(0, 7);
                end
                else
                begin
                    byte_if.in_byte <= pending[0].b;
                    byte_if.valid   <= 1'b1;
                    void'(pending.pop_front());
                end
            end
        end
    end

    // Receiver ready: short random stalls and one long hold-off to back up the block
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_if.ready    <= 1'b0;
            stall_left      <= 0;
            long_stall_done <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            tag_if.ready <= (stall_left == 1);
            stall_left   <= stall_left - 1;
        end
        else if (!long_stall_done && accepted_cnt >= STALL_AT)
        begin
            tag_if.ready    <= 1'b0;
            stall_left      <= LONG_STALL;
            long_stall_done <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            // random burst of stalled cycles
            tag_if.ready <= 1'b0;
            stall_left   <= $urandom_range(1, 8);
        end
        else
            tag_if.ready <= 1'b1;
    end

    // Monitor: every returned byte against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : tag_monitor
        spd_result_t want;
        if (!rst_n)
            checked_cnt <= 0;
        else if (tag_if.valid && tag_if.ready)
        begin
            checked_cnt <= checked_cnt + 1;
            if (tagged_due.size() == 0)
            begin
                $display("%0t ns: unexpected tagged byte, expected none, got out_byte %0d",
                         $time, tag_if.out_byte);
                errors++;
            end
            else
            begin
                want = tagged_due.pop_front();
                compare_field("out_byte", want.out_byte, tag_if.out_byte);
                compare_field("position", want.position, tag_if.position);
                compare_field("packet_type", want.packet_type, tag_if.packet_type);
                compare_field("is_header", want.is_header, tag_if.is_header);
                compare_field("has_payload", want.has_payload, tag_if.has_payload);
                compare_field("last", want.last, tag_if.last);
                compare_field("checksum_error", want.checksum_error,
                              tag_if.checksum_error);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        logic [BYTE_W-1:0] ptype;
        logic [BYTE_W-1:0] arg1;
        int unsigned       kind;
        bit                mid_drain_done;
        bit                max_pkt_done;
        byte_if.valid   = 1'b0;
        byte_if.in_byte = '0;
        tag_if.ready    = 1'b0;
        cycle_cnt       = 0;
        errors          = 0;
        drain_next      = 1'b0;
        mid_drain_done  = 1'b0;
        max_pkt_done    = 1'b0;
        total_items     = '1;

        // Directed: header-only extremes, zero-length payload good and bad, short payload
        queue_packet(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        queue_packet(8'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        queue_packet(8'h80, 8'h00, 8'h00, 8'h00, 1'b1);
        queue_packet(8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b0);
        queue_packet(8'h8A, 8'h02, 8'h5A, 8'hA5, 1'b1);

        // Random packets, mostly well formed; sender drains first at the start
        drain_next = 1'b1;
        while (pending.size() < RANDOM_BYTES + 25)
        begin
            if (!mid_drain_done && pending.size() > 700)
            begin
                drain_next = 1'b1;
                mid_drain_done = 1'b1;
            end
            kind = $urandom_range(0, 19);
            if (!max_pkt_done && pending.size() > 300)
            begin
                // longest packet: positions up to 259
                ptype = BYTE_W'($urandom);
                ptype[PAYLOAD_FLAG_BIT] = 1'b1;
                queue_packet(ptype, 8'hFF, BYTE_W'($urandom), BYTE_W'($urandom), 1'b1);
                max_pkt_done = 1'b1;
            end
            else if (kind == 0)
            begin
                // junk packet: any type, any length, checksum byte random
                ptype = BYTE_W'($urandom);
                arg1  = BYTE_W'($urandom);
                queue_packet(ptype, arg1, BYTE_W'($urandom), BYTE_W'($urandom),
                             $urandom_range(0, 7) == 0);
            end
            else if (kind <= 8)
            begin
                ptype = BYTE_W'($urandom_range(0, 127));
                queue_packet(ptype, BYTE_W'($urandom), BYTE_W'($urandom),
                             BYTE_W'($urandom), 1'b1);
            end
            else
            begin
                ptype = BYTE_W'($urandom);
                ptype[PAYLOAD_FLAG_BIT] = 1'b1;
                if ($urandom_range(0, 99) < 3)
                    arg1 = BYTE_W'($urandom);
                else
                    arg1 = BYTE_W'($urandom_range(0, 12));
                queue_packet(ptype, arg1, BYTE_W'($urandom), BYTE_W'($urandom),
                             $urandom_range(0, 3) != 0);
            end
        end
        total_items = pending.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every byte to be sent and every tagged byte to return
        @(negedge clk);
        while (pending.size() != 0 || byte_if.valid || accepted_cnt != checked_cnt)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (tagged_due.size() != 0)
        begin
            $display("%0t ns: expected %0d more tagged bytes, got none", $time,
                     tagged_due.size());
            errors++;
        end
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
rtl/core/spd_pkg.sv
rtl/core/spd_in_if.sv
rtl/core/spd_out_if.sv
rtl/core/spd_input_stage.sv
rtl/core/spd_tracker.sv
rtl/core/spd_output_stage.sv
rtl/core/serial_packet_deframer.sv
dv/serial_packet_deframer_tb.sv
